[hw/rtl/tcp_pkg.sv]
package tcp_pkg;

  localparam int CW        = 32;          // coordinate width, signed Q16.16
  localparam int DW        = 2 * CW + 2;  // signed plane distance, exact
  localparam int MW        = DW - 1;      // magnitude of a distance
  localparam int QW        = CW;          // quotient width of one crossing step
  localparam int DIV_STEPS = QW;
  localparam int DIV_LAT   = DIV_STEPS + 4;
  localparam int DIST_LAT  = 2;
  localparam int CFG_IW    = 3;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] dist_t;

  // x sits in the lowest bits, v0 in the lowest vertex
  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } vec3_t;

  typedef struct packed {
    vec3_t v2;
    vec3_t v1;
    vec3_t v0;
  } tri_t;

  localparam int TRI_W = $bits(tri_t);

  // keep mask: bit i set when vertex i lies on or in front of the plane
  typedef logic [2:0] keep_t;
  localparam keep_t KEEP_NONE = 3'b000;
  localparam keep_t KEEP_V0   = 3'b001;
  localparam keep_t KEEP_V1   = 3'b010;
  localparam keep_t KEEP_V01  = 3'b011;
  localparam keep_t KEEP_V2   = 3'b100;
  localparam keep_t KEEP_V02  = 3'b101;
  localparam keep_t KEEP_V12  = 3'b110;
  localparam keep_t KEEP_ALL  = 3'b111;

  typedef enum logic [1:0] {
    EDGE_01,
    EDGE_12,
    EDGE_20
  } sel_edge_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_PT_X,
    REG_PT_Y,
    REG_PT_Z,
    REG_N_X,
    REG_N_Y,
    REG_N_Z
  } cfg_reg_t;

  // one pass through the pipeline: ph 0 carries the first crossing,
  // ph 1 the second one and emits the triangles
  typedef struct packed {
    logic  ph;
    keep_t keep;
    tri_t  verts;
  } job_t;

endpackage

[hw/rtl/tcp_dist.sv]
module tcp_dist (
  input  logic           clk,
  input  logic           en,
  input  tcp_pkg::vec3_t v,
  input  tcp_pkg::vec3_t pt,
  input  tcp_pkg::vec3_t nrm,
  output tcp_pkg::dist_t vdist
);
  import tcp_pkg::*;

  localparam int PW = 2 * CW + 1;

  logic signed [CW:0]   dx, dy, dz;
  logic signed [PW-1:0] px_r, py_r, pz_r;
  logic signed [PW-1:0] px_nxt, py_nxt, pz_nxt;
  dist_t                dist_r, dist_nxt;

  always_comb begin
    dx       = (CW+1)'(v.x) - (CW+1)'(pt.x);
    dy       = (CW+1)'(v.y) - (CW+1)'(pt.y);
    dz       = (CW+1)'(v.z) - (CW+1)'(pt.z);
    px_nxt   = PW'(dx) * PW'(nrm.x);
    py_nxt   = PW'(dy) * PW'(nrm.y);
    pz_nxt   = PW'(dz) * PW'(nrm.z);
    dist_nxt = DW'(px_r) + DW'(py_r) + DW'(pz_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      pz_r   <= pz_nxt;
      dist_r <= dist_nxt;
    end
  end

  assign vdist = dist_r;

endmodule

[hw/rtl/tcp_div.sv]
module tcp_div (
  input  logic            clk,
  input  logic            en,
  input  tcp_pkg::coord_t a,
  input  tcp_pkg::coord_t b,
  input  tcp_pkg::dist_t  da,
  input  tcp_pkg::dist_t  db,
  output tcp_pkg::coord_t res
);
  import tcp_pkg::*;

  localparam int RW    = MW + 1;
  localparam int PW    = MW + QW;
  localparam int LO_W  = (MW + 1) / 2;
  localparam int HI_W  = MW - LO_W;
  localparam int PLO_W = LO_W + QW;
  localparam int PHI_W = HI_W + QW;

  // stage 1: edge delta and distance magnitudes
  logic signed [CW:0] diff, diff_abs;
  dist_t              da_abs, db_abs;
  coord_t             a1_r;
  logic [QW-1:0]      m1_r;
  logic               neg1_r;
  logic [MW-1:0]      na1_r, nb1_r;

  // stage 2: denominator and split product
  coord_t             a2_r;
  logic [QW-1:0]      m2_r;
  logic               neg2_r;
  logic [RW-1:0]      den2_r;
  logic [PLO_W-1:0]   plo2_r;
  logic [PHI_W-1:0]   phi2_r;

  // stage 3 onward: restoring divider, one quotient bit per stage
  logic [PW-1:0]      prod;
  logic [RW-1:0]      r_r    [0:DIV_STEPS];
  logic [QW-1:0]      bits_r [0:DIV_STEPS];
  logic [QW-1:0]      q_r    [0:DIV_STEPS];
  logic [RW-1:0]      den_r  [0:DIV_STEPS];
  coord_t             a_r    [0:DIV_STEPS];
  logic [QW-1:0]      m_r    [0:DIV_STEPS];
  logic               neg_r  [0:DIV_STEPS];

  // final stage: round, clamp, step from a
  logic               up;
  logic [QW:0]        qr;
  logic [CW+1:0]      sum;
  coord_t             res_r, res_nxt;

  always_comb begin
    diff     = (CW+1)'(b) - (CW+1)'(a);
    diff_abs = diff[CW] ? -diff : diff;
    da_abs   = da[DW-1] ? -da : da;
    db_abs   = db[DW-1] ? -db : db;
    prod     = (PW'(phi2_r) << LO_W) + PW'(plo2_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r      <= a;
      m1_r      <= diff_abs[QW-1:0];
      neg1_r    <= diff[CW];
      na1_r     <= da_abs[MW-1:0];
      nb1_r     <= db_abs[MW-1:0];

      a2_r      <= a1_r;
      m2_r      <= m1_r;
      neg2_r    <= neg1_r;
      den2_r    <= RW'(na1_r) + RW'(nb1_r);
      plo2_r    <= PLO_W'(na1_r[LO_W-1:0]) * PLO_W'(m1_r);
      phi2_r    <= PHI_W'(na1_r[MW-1:LO_W]) * PHI_W'(m1_r);

      r_r[0]    <= RW'(prod[PW-1:QW]);
      bits_r[0] <= prod[QW-1:0];
      q_r[0]    <= '0;
      den_r[0]  <= den2_r;
      a_r[0]    <= a2_r;
      m_r[0]    <= m2_r;
      neg_r[0]  <= neg2_r;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [RW:0] trial;
    logic        fit;

    always_comb begin
      trial = {r_r[k], bits_r[k][QW-1]};
      fit   = trial >= {1'b0, den_r[k]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k+1]    <= fit ? RW'(trial - {1'b0, den_r[k]}) : trial[RW-1:0];
        bits_r[k+1] <= {bits_r[k][QW-2:0], 1'b0};
        q_r[k+1]    <= {q_r[k][QW-2:0], fit};
        den_r[k+1]  <= den_r[k];
        a_r[k+1]    <= a_r[k];
        m_r[k+1]    <= m_r[k];
        neg_r[k+1]  <= neg_r[k];
      end
    end
  end

  always_comb begin
    up = {r_r[DIV_STEPS], 1'b0} >= {1'b0, den_r[DIV_STEPS]};
    qr = {1'b0, q_r[DIV_STEPS]} + (QW+1)'(up);
    if (qr > {1'b0, m_r[DIV_STEPS]}) begin
      qr = {1'b0, m_r[DIV_STEPS]};
    end
    if (neg_r[DIV_STEPS]) begin
      sum = (CW+2)'(a_r[DIV_STEPS]) - (CW+2)'(qr);
    end else begin
      sum = (CW+2)'(a_r[DIV_STEPS]) + (CW+2)'(qr);
    end
    if (sum[CW+1:CW-1] == 3'b000 || sum[CW+1:CW-1] == 3'b111) begin
      res_nxt = sum[CW-1:0];
    end else if (sum[CW+1]) begin
      res_nxt = {1'b1, {(CW-1){1'b0}}};
    end else begin
      res_nxt = {1'b0, {(CW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

[hw/rtl/tcp_merge.sv]
module tcp_merge (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      job_v,
  input  tcp_pkg::job_t             job,
  input  tcp_pkg::vec3_t            xing,
  output logic                      stall,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [tcp_pkg::TRI_W-1:0] out_tdata,
  output logic                      out_tlast
);
  import tcp_pkg::*;

  logic [1:0] cnt_r, cnt_nxt;
  tri_t       slot_r   [0:1];
  tri_t       slot_nxt [0:1];
  logic       last_r   [0:1];
  logic       last_nxt [0:1];
  vec3_t      cross_a_r;

  logic       pop, take;
  logic [1:0] remain, n;
  logic [2:0] fill;
  tri_t       t1, t2;
  vec3_t      v0, v1, v2, ca, cb;

  always_comb begin
    v0 = job.verts.v0;
    v1 = job.verts.v1;
    v2 = job.verts.v2;
    ca = cross_a_r;
    cb = xing;
    n  = 2'd0;
    t1 = job.verts;
    t2 = job.verts;
    case (job.keep)
      KEEP_NONE: n = 2'd0;
      KEEP_ALL:  n = 2'd1;
      KEEP_V0: begin
        n  = 2'd1;
        t1 = '{v2: cb, v1: ca, v0: v0};
      end
      KEEP_V1: begin
        n  = 2'd1;
        t1 = '{v2: cb, v1: ca, v0: v1};
      end
      KEEP_V2: begin
        n  = 2'd1;
        t1 = '{v2: cb, v1: ca, v0: v2};
      end
      KEEP_V01: begin
        n  = 2'd2;
        t1 = '{v2: cb, v1: v1, v0: v0};
        t2 = '{v2: cb, v1: ca, v0: v1};
      end
      KEEP_V12: begin
        n  = 2'd2;
        t1 = '{v2: ca, v1: v2, v0: v1};
        t2 = '{v2: ca, v1: cb, v0: v2};
      end
      KEEP_V02: begin
        n  = 2'd2;
        t1 = '{v2: cb, v1: v0, v0: v2};
        t2 = '{v2: cb, v1: ca, v0: v0};
      end
      default: n = 2'd0;
    endcase

    pop    = out_tvalid && out_tready;
    remain = cnt_r - 2'(pop);
    take   = job_v && job.ph;
    fill   = 3'(remain) + 3'(n);
    stall  = take && (fill > 3'd2);

    slot_nxt[0] = slot_r[0];
    slot_nxt[1] = slot_r[1];
    last_nxt[0] = last_r[0];
    last_nxt[1] = last_r[1];
    if (pop) begin
      slot_nxt[0] = slot_r[1];
      last_nxt[0] = last_r[1];
    end
    cnt_nxt = remain;
    if (take && !stall) begin
      cnt_nxt = fill[1:0];
      if (remain == 2'd0) begin
        slot_nxt[0] = t1;
        last_nxt[0] = (n == 2'd1);
        slot_nxt[1] = t2;
        last_nxt[1] = 1'b1;
      end else if (n != 2'd0) begin
        slot_nxt[1] = t1;
        last_nxt[1] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r[0] <= slot_nxt[0];
    slot_r[1] <= slot_nxt[1];
    last_r[0] <= last_nxt[0];
    last_r[1] <= last_nxt[1];
    if (job_v && !job.ph) begin
      cross_a_r <= xing;
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = slot_r[0];
  assign out_tlast  = last_r[0];

endmodule

[hw/rtl/triangle_clip_against_plane_3d.sv]
// Clip one triangle against a plane held in configuration registers.
//
// Input channel in_*: one triangle per item, nine signed Q16.16 words.
// Output channel out_*: zero, one or two triangles per input item; tlast
// marks the final triangle of an item. An item with every vertex behind
// the plane yields nothing at all.
// Configuration: cfg_we writes cfg_wdata into register cfg_idx (plane
// point x/y/z, normal x/y/z); indexes beyond those are ignored. Write
// only while the block is empty.
//
// Each item makes two passes through the pipeline, one per edge crossing,
// so in_tready is low while a held item still has its first pass to issue
// and while the pipeline is stalled. A pass runs through the dot products
// and then the crossing lanes, whose restoring divider resolves one
// quotient bit per stage; a second triangle of an item is offered in the
// cycle after the first one is taken.
// Reset clears the plane to point 0 and normal (1.0, 0, 0) and drops all
// work in flight. A two-entry output buffer absorbs receiver stalls; the
// pipeline freezes only when a finished pass finds no room there.
module triangle_clip_against_plane_3d (
  input  logic                      clk,
  input  logic                      rst_n,
  // slave side: in_tdata = v0.x, v0.y, v0.z, v1.x, ... v2.z (lowest first)
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [tcp_pkg::TRI_W-1:0] in_tdata,
  // master side: out_tdata = v0.x, v0.y, v0.z, v1.x, ... v2.z (lowest first)
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [tcp_pkg::TRI_W-1:0] out_tdata,
  output logic                      out_tlast,
  // configuration write port
  input  logic                      cfg_we,
  input  logic [tcp_pkg::CFG_IW-1:0] cfg_idx,
  input  logic [tcp_pkg::CW-1:0]    cfg_wdata
);
  import tcp_pkg::*;

  localparam int     SB_N      = DIST_LAT + DIV_LAT;
  localparam coord_t NRM_X_RST = 32'sd65536;

  // plane registers
  vec3_t pt_r, nrm_r;

  // input holding stage: issues ph 0, then ph 1
  logic  s0_v_r, s0_ph_r;
  tri_t  s0_tri_r;
  logic  en, stall, accept;

  // distance lanes, one per vertex
  dist_t d0, d1, d2;
  keep_t keep_d;

  // sideband that travels beside the lanes
  logic [SB_N-1:0] sb_v_r;
  job_t            sb_r   [0:SB_N-1];
  job_t            sb_nxt [0:SB_N-1];

  // crossing lanes, one per coordinate
  sel_edge_t sel;
  job_t      cur;
  vec3_t     ea, eb, xing;
  dist_t     eda, edb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_r  <= '0;
      nrm_r <= '{z: '0, y: '0, x: NRM_X_RST};
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_PT_X: pt_r.x  <= cfg_wdata;
        REG_PT_Y: pt_r.y  <= cfg_wdata;
        REG_PT_Z: pt_r.z  <= cfg_wdata;
        REG_N_X:  nrm_r.x <= cfg_wdata;
        REG_N_Y:  nrm_r.y <= cfg_wdata;
        REG_N_Z:  nrm_r.z <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together; hold everything while the merge
  // stage cannot take its pass.
  assign en        = !stall;
  assign in_tready = en && (!s0_v_r || s0_ph_r);
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r  <= 1'b0;
      s0_ph_r <= 1'b0;
    end else if (en) begin
      if (accept) begin
        s0_v_r  <= 1'b1;
        s0_ph_r <= 1'b0;
      end else if (s0_v_r && !s0_ph_r) begin
        s0_ph_r <= 1'b1;
      end else begin
        s0_v_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_tri_r <= tri_t'(in_tdata);
    end
  end

  tcp_dist u_dist0 (.clk(clk), .en(en), .v(s0_tri_r.v0), .pt(pt_r), .nrm(nrm_r),
                    .vdist(d0));
  tcp_dist u_dist1 (.clk(clk), .en(en), .v(s0_tri_r.v1), .pt(pt_r), .nrm(nrm_r),
                    .vdist(d1));
  tcp_dist u_dist2 (.clk(clk), .en(en), .v(s0_tri_r.v2), .pt(pt_r), .nrm(nrm_r),
                    .vdist(d2));

  // a vertex on the plane counts as kept
  assign keep_d = {~d2[DW-1], ~d1[DW-1], ~d0[DW-1]};

  always_comb begin
    sb_nxt[0] = '{ph: s0_ph_r, keep: KEEP_NONE, verts: s0_tri_r};
    for (int i = 1; i < SB_N; i++) begin
      sb_nxt[i] = sb_r[i-1];
    end
    // the keep mask joins the sideband once the distances are out
    sb_nxt[DIST_LAT].keep = keep_d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_v_r <= '0;
    end else if (en) begin
      sb_v_r <= {sb_v_r[SB_N-2:0], s0_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r <= sb_nxt;
    end
  end

  // Pick the crossed edge for this pass: ph 0 takes the lowest crossed
  // edge (v0v1, v1v2, v2v0 order), ph 1 the highest.
  always_comb begin
    cur = sb_r[DIST_LAT-1];
    if (!cur.ph) begin
      if (keep_d[0] ^ keep_d[1]) begin
        sel = EDGE_01;
      end else if (keep_d[1] ^ keep_d[2]) begin
        sel = EDGE_12;
      end else begin
        sel = EDGE_20;
      end
    end else begin
      if (keep_d[2] ^ keep_d[0]) begin
        sel = EDGE_20;
      end else if (keep_d[1] ^ keep_d[2]) begin
        sel = EDGE_12;
      end else begin
        sel = EDGE_01;
      end
    end
    case (sel)
      EDGE_01: begin
        ea = cur.verts.v0; eb = cur.verts.v1; eda = d0; edb = d1;
      end
      EDGE_12: begin
        ea = cur.verts.v1; eb = cur.verts.v2; eda = d1; edb = d2;
      end
      EDGE_20: begin
        ea = cur.verts.v2; eb = cur.verts.v0; eda = d2; edb = d0;
      end
      default: begin
        ea = cur.verts.v0; eb = cur.verts.v1; eda = d0; edb = d1;
      end
    endcase
  end

  tcp_div u_div_x (.clk(clk), .en(en), .a(ea.x), .b(eb.x), .da(eda), .db(edb),
                   .res(xing.x));
  tcp_div u_div_y (.clk(clk), .en(en), .a(ea.y), .b(eb.y), .da(eda), .db(edb),
                   .res(xing.y));
  tcp_div u_div_z (.clk(clk), .en(en), .a(ea.z), .b(eb.z), .da(eda), .db(edb),
                   .res(xing.z));

  // Merge: keep the first crossing, build triangles on the second pass.
  tcp_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_v      (sb_v_r[SB_N-1]),
    .job        (sb_r[SB_N-1]),
    .xing       (xing),
    .stall      (stall),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[hw/rtl/tcp_chk.sv]
module tcp_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [tcp_pkg::TRI_W-1:0] out_tdata,
  input logic                      out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("output item changed while stalled");

  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("second triangle of a pair not ready");

  a_two_cycle_issue: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted on consecutive cycles");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind triangle_clip_against_plane_3d tcp_chk u_tcp_chk (.*);
